// File: src/tcc_pkg.sv
// Package for the tilt-compensated compass: datapath widths, CORDIC types and helper functions.
`default_nettype none
package tcc_pkg;

    // Working width of the vector components and of the angle accumulator.
    localparam int XW = 36;
    localparam int ZW = 34;
    localparam int TabLen = 24;
    localparam logic signed [ZW-1:0] HalfPi = ZW'(64'sd1073741824);
    localparam logic [30:0] InvGain = 31'd652032874;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cv;

    // Arctangent of 2^-i, with pi equal to 2^31.
    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            default: v = 32'h00000051;
        endcase
        return $signed({{(ZW-32){1'b0}}, v});
    endfunction

    // Removes the CORDIC gain: v * (1/K in Q30), rounded, shifted down by 30.
    function automatic logic signed [XW-1:0] unscale(input logic signed [XW-1:0] v);
        logic signed [XW+31:0] a;
        logic signed [XW+31:0] b;
        logic signed [XW+31:0] p;
        a = {{32{v[XW-1]}}, v};
        b = $signed({{(XW+1){1'b0}}, InvGain});
        p = a * b + $signed((XW+32)'(64'd536870912));
        return p[XW+29:30];
    endfunction

    // Moves a vector with negative x into the right half plane before vectoring.
    function automatic t_cv vec_prep(input logic signed [XW-1:0] x,
                                     input logic signed [XW-1:0] y);
        t_cv r;
        r.x = x;
        r.y = y;
        r.z = '0;
        if (x < 0) begin
            if (y >= 0) begin
                r.x = y;
                r.y = -x;
                r.z = HalfPi;
            end else begin
                r.x = -y;
                r.y = x;
                r.z = -HalfPi;
            end
        end
        return r;
    endfunction

    // Brings a rotation angle within plus/minus pi/2 by a quarter turn.
    function automatic t_cv rot_prep(input logic signed [XW-1:0] x,
                                     input logic signed [XW-1:0] y,
                                     input logic signed [ZW-1:0] a);
        t_cv r;
        r.x = x;
        r.y = y;
        r.z = a;
        if (a > HalfPi) begin
            r.x = -y;
            r.y = x;
            r.z = a - HalfPi;
        end else if (a < -HalfPi) begin
            r.x = y;
            r.y = -x;
            r.z = a + HalfPi;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/tcc_vec_cell.sv
// One vectoring CORDIC iteration with its pipeline register and a carried side word.
`default_nettype none
module tcc_vec_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire tcc_pkg::t_cv        i_cv,
    input  wire logic [SIDE_W-1:0]   i_side,
    output logic                     o_valid,
    output tcc_pkg::t_cv             o_cv,
    output logic [SIDE_W-1:0]        o_side
);

    localparam logic signed [tcc_pkg::ZW-1:0] Ang = tcc_pkg::atan_entry(STEP);

    logic signed [tcc_pkg::XW-1:0] dx;
    logic signed [tcc_pkg::XW-1:0] dy;
    tcc_pkg::t_cv n_cv;

    assign dx = i_cv.y >>> STEP;
    assign dy = i_cv.x >>> STEP;

    always_comb begin
        if (i_cv.y > 0) begin
            n_cv.x = i_cv.x + dx;
            n_cv.y = i_cv.y - dy;
            n_cv.z = i_cv.z + Ang;
        end else begin
            n_cv.x = i_cv.x - dx;
            n_cv.y = i_cv.y + dy;
            n_cv.z = i_cv.z - Ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cv   <= n_cv;
            o_side <= i_side;
        end
    end

endmodule
`default_nettype wire

// File: src/tcc_rot_cell.sv
// One rotation CORDIC iteration with its pipeline register and a carried side word.
`default_nettype none
module tcc_rot_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire tcc_pkg::t_cv        i_cv,
    input  wire logic [SIDE_W-1:0]   i_side,
    output logic                     o_valid,
    output tcc_pkg::t_cv             o_cv,
    output logic [SIDE_W-1:0]        o_side
);

    localparam logic signed [tcc_pkg::ZW-1:0] Ang = tcc_pkg::atan_entry(STEP);

    logic signed [tcc_pkg::XW-1:0] dx;
    logic signed [tcc_pkg::XW-1:0] dy;
    tcc_pkg::t_cv n_cv;

    assign dx = i_cv.y >>> STEP;
    assign dy = i_cv.x >>> STEP;

    always_comb begin
        if (i_cv.z >= 0) begin
            n_cv.x = i_cv.x - dx;
            n_cv.y = i_cv.y + dy;
            n_cv.z = i_cv.z - Ang;
        end else begin
            n_cv.x = i_cv.x + dx;
            n_cv.y = i_cv.y - dy;
            n_cv.z = i_cv.z + Ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cv   <= n_cv;
            o_side <= i_side;
        end
    end

endmodule
`default_nettype wire

// File: src/tilt_compensated_compass.sv
// Top level of the tilt-compensated compass: five CORDIC cell rows with gain and setup stages.
//
// Usage: the input channel (i_valid, o_stall) carries one item of six signed samples,
// three accelerometer axes and three magnetometer axes. The output channel
// (o_valid, i_stall) carries one item of three binary angles: roll, pitch and
// tilt-compensated heading, with half of full scale equal to pi.
// Each item passes through a roll vectoring row, then a pitch vectoring row that runs
// beside the row rotating the magnetometer by roll, then a row rotating by pitch, and
// finally the heading vectoring row. Every row has one cell per CORDIC iteration.
// The number of iterations N is CORDIC_STEPS capped at 24. Throughput is one item per
// clock cycle while the receiver does not stall: each cell holds one item and hands it
// to the next cell in every cycle that the pipeline moves.
// The whole pipeline moves as one unit. It stops only while the output register holds
// an item and the receiver stalls; o_stall then goes high at the input in the same cycle.
// Bubbles move through like any item, so a stall is never needed while the output is empty.
// Reset clears every valid bit; no item is in flight afterwards and no result appears
// until an item is accepted. The block holds no state between items.
`default_nettype none
module tilt_compensated_compass #(
    parameter int SAMPLE_BITS  = 16,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input  wire logic signed [SAMPLE_BITS-1:0] i_accel_y,
    input  wire logic signed [SAMPLE_BITS-1:0] i_accel_z,
    input  wire logic signed [SAMPLE_BITS-1:0] i_mag_x,
    input  wire logic signed [SAMPLE_BITS-1:0] i_mag_y,
    input  wire logic signed [SAMPLE_BITS-1:0] i_mag_z,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [ANGLE_BITS-1:0]       o_roll_angle,
    output logic signed [ANGLE_BITS-1:0]       o_pitch_angle,
    output logic signed [ANGLE_BITS-1:0]       o_heading_angle
);

    localparam int XW = tcc_pkg::XW;
    localparam int ZW = tcc_pkg::ZW;
    localparam int N = (CORDIC_STEPS < tcc_pkg::TabLen) ? CORDIC_STEPS : tcc_pkg::TabLen;
    localparam int PreShift = 31 - SAMPLE_BITS;

    // Side word widths of the rows.
    localparam int S1W = 1 + 3 * XW;       // zero flag, ax, mx, my
    localparam int S2VW = 3;               // gz2 zero, ax negative, ax nonzero
    localparam int S2RW = ZW + XW;         // roll, mx
    localparam int S4W = 2 * ZW + XW;      // roll, pitch, By2
    localparam int S5W = 2 * ZW + 1;       // roll, pitch, zero flag

    logic en;

    // The pipeline advances unless a finished item waits at a stalled receiver.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Input scaling: sign extension, then magnitude up to 2^30.
    logic signed [XW-1:0] ax_s, ay_s, az_s, mx_s, my_s, mz_s;
    assign ax_s = $signed({{(XW-SAMPLE_BITS){i_accel_x[SAMPLE_BITS-1]}}, i_accel_x}) <<< PreShift;
    assign ay_s = $signed({{(XW-SAMPLE_BITS){i_accel_y[SAMPLE_BITS-1]}}, i_accel_y}) <<< PreShift;
    assign az_s = $signed({{(XW-SAMPLE_BITS){i_accel_z[SAMPLE_BITS-1]}}, i_accel_z}) <<< PreShift;
    assign mx_s = $signed({{(XW-SAMPLE_BITS){i_mag_x[SAMPLE_BITS-1]}}, i_mag_x}) <<< PreShift;
    assign my_s = $signed({{(XW-SAMPLE_BITS){i_mag_y[SAMPLE_BITS-1]}}, i_mag_y}) <<< PreShift;
    assign mz_s = $signed({{(XW-SAMPLE_BITS){i_mag_z[SAMPLE_BITS-1]}}, i_mag_z}) <<< PreShift;

    // ---------------- Setup stage for the roll row ----------------
    // The accelerometer x axis and the magnetometer x and y axes ride along in the side
    // word; the magnetometer z axis is delayed in a register chain of its own.
    logic                 r_p1_valid;
    tcc_pkg::t_cv         r_p1_cv;
    logic [S1W-1:0]       r_p1_side;
    logic signed [XW-1:0] r_p1_mz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (en) begin
            r_p1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_cv   <= tcc_pkg::vec_prep(az_s, ay_s);
            r_p1_side <= {(ay_s == 0 && az_s == 0), ax_s, mx_s, my_s};
            r_p1_mz   <= mz_s;
        end
    end

    // ---------------- Roll vectoring row ----------------
    logic                 w1_valid [0:N];
    tcc_pkg::t_cv         w1_cv    [0:N];
    logic [S1W-1:0]       w1_side  [0:N];
    logic signed [XW-1:0] w1_mz    [0:N];

    assign w1_valid[0] = r_p1_valid;
    assign w1_cv[0]    = r_p1_cv;
    assign w1_side[0]  = r_p1_side;
    assign w1_mz[0]    = r_p1_mz;

    for (genvar k = 0; k < N; k++) begin : g_row1
        tcc_vec_cell #(.STEP(k), .SIDE_W(S1W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w1_valid[k]),
            .i_cv    (w1_cv[k]),
            .i_side  (w1_side[k]),
            .o_valid (w1_valid[k+1]),
            .o_cv    (w1_cv[k+1]),
            .o_side  (w1_side[k+1])
        );
        // The magnetometer z axis is delayed in step with the cell.
        always_ff @(posedge i_clk) begin
            if (en) begin
                w1_mz[k+1] <= w1_mz[k];
            end
        end
    end

    // ---------------- Gain stage after roll ----------------
    logic                 r_u1_valid;
    logic signed [ZW-1:0] r_u1_roll;
    logic signed [XW-1:0] r_u1_gz2;
    logic signed [XW-1:0] r_u1_ax, r_u1_mx, r_u1_my, r_u1_mz;
    logic                 u1_zero;

    assign u1_zero = w1_side[N][S1W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u1_valid <= 1'b0;
        end else if (en) begin
            r_u1_valid <= w1_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u1_roll <= u1_zero ? '0 : w1_cv[N].z;
            r_u1_gz2  <= u1_zero ? '0 : tcc_pkg::unscale(w1_cv[N].x);
            r_u1_ax   <= $signed(w1_side[N][3*XW-1:2*XW]);
            r_u1_mx   <= $signed(w1_side[N][2*XW-1:XW]);
            r_u1_my   <= $signed(w1_side[N][XW-1:0]);
            r_u1_mz   <= w1_mz[N];
        end
    end

    // ---------------- Setup stage for pitch and the first rotation ----------------
    logic                 r_p2_valid;
    tcc_pkg::t_cv         r_p2_vcv;
    tcc_pkg::t_cv         r_p2_rcv;
    logic [S2VW-1:0]      r_p2_vside;
    logic [S2RW-1:0]      r_p2_rside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (en) begin
            r_p2_valid <= r_u1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_vcv   <= tcc_pkg::vec_prep(r_u1_gz2, -r_u1_ax);
            r_p2_rcv   <= tcc_pkg::rot_prep(r_u1_mz, r_u1_my, -r_u1_roll);
            r_p2_vside <= {(r_u1_gz2 == 0), (r_u1_ax < 0), (r_u1_ax != 0)};
            r_p2_rside <= {r_u1_roll, r_u1_mx};
        end
    end

    // ---------------- Pitch vectoring row beside the roll rotation row ----------------
    logic                 w2v_valid [0:N];
    tcc_pkg::t_cv         w2v_cv    [0:N];
    logic [S2VW-1:0]      w2v_side  [0:N];
    logic                 w2r_valid [0:N];
    tcc_pkg::t_cv         w2r_cv    [0:N];
    logic [S2RW-1:0]      w2r_side  [0:N];

    assign w2v_valid[0] = r_p2_valid;
    assign w2v_cv[0]    = r_p2_vcv;
    assign w2v_side[0]  = r_p2_vside;
    assign w2r_valid[0] = r_p2_valid;
    assign w2r_cv[0]    = r_p2_rcv;
    assign w2r_side[0]  = r_p2_rside;

    for (genvar k = 0; k < N; k++) begin : g_row2
        tcc_vec_cell #(.STEP(k), .SIDE_W(S2VW)) u_vcell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w2v_valid[k]),
            .i_cv    (w2v_cv[k]),
            .i_side  (w2v_side[k]),
            .o_valid (w2v_valid[k+1]),
            .o_cv    (w2v_cv[k+1]),
            .o_side  (w2v_side[k+1])
        );
        tcc_rot_cell #(.STEP(k), .SIDE_W(S2RW)) u_rcell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w2r_valid[k]),
            .i_cv    (w2r_cv[k]),
            .i_side  (w2r_side[k]),
            .o_valid (w2r_valid[k+1]),
            .o_cv    (w2r_cv[k+1]),
            .o_side  (w2r_side[k+1])
        );
    end

    // ---------------- Gain stage and pitch saturation ----------------
    logic                 r_u2_valid;
    logic signed [ZW-1:0] r_u2_roll;
    logic signed [ZW-1:0] r_u2_pitch;
    logic signed [XW-1:0] r_u2_mx;
    logic signed [XW-1:0] r_u2_bz;
    logic signed [XW-1:0] r_u2_byn;
    logic signed [ZW-1:0] n_pitch;

    // A zero vertical component gives plus or minus pi/2 from the sign of ax, or zero.
    always_comb begin
        if (w2v_side[N][2]) begin
            if (w2v_side[N][1]) begin
                n_pitch = tcc_pkg::HalfPi;
            end else if (w2v_side[N][0]) begin
                n_pitch = -tcc_pkg::HalfPi;
            end else begin
                n_pitch = '0;
            end
        end else if (w2v_cv[N].z > tcc_pkg::HalfPi) begin
            n_pitch = tcc_pkg::HalfPi;
        end else if (w2v_cv[N].z < -tcc_pkg::HalfPi) begin
            n_pitch = -tcc_pkg::HalfPi;
        end else begin
            n_pitch = w2v_cv[N].z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u2_valid <= 1'b0;
        end else if (en) begin
            r_u2_valid <= w2v_valid[N] && w2r_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u2_pitch <= n_pitch;
            r_u2_roll  <= $signed(w2r_side[N][S2RW-1:XW]);
            r_u2_mx    <= $signed(w2r_side[N][XW-1:0]);
            r_u2_bz    <= tcc_pkg::unscale(w2r_cv[N].x);
            r_u2_byn   <= tcc_pkg::unscale(w2r_cv[N].y);
        end
    end

    // ---------------- Setup stage for the pitch rotation ----------------
    logic                 r_p4_valid;
    tcc_pkg::t_cv         r_p4_cv;
    logic [S4W-1:0]       r_p4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_valid <= 1'b0;
        end else if (en) begin
            r_p4_valid <= r_u2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p4_cv   <= tcc_pkg::rot_prep(r_u2_mx, r_u2_bz, -r_u2_pitch);
            r_p4_side <= {r_u2_roll, r_u2_pitch, -r_u2_byn};
        end
    end

    // ---------------- Pitch rotation row ----------------
    logic                 w4_valid [0:N];
    tcc_pkg::t_cv         w4_cv    [0:N];
    logic [S4W-1:0]       w4_side  [0:N];

    assign w4_valid[0] = r_p4_valid;
    assign w4_cv[0]    = r_p4_cv;
    assign w4_side[0]  = r_p4_side;

    for (genvar k = 0; k < N; k++) begin : g_row4
        tcc_rot_cell #(.STEP(k), .SIDE_W(S4W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w4_valid[k]),
            .i_cv    (w4_cv[k]),
            .i_side  (w4_side[k]),
            .o_valid (w4_valid[k+1]),
            .o_cv    (w4_cv[k+1]),
            .o_side  (w4_side[k+1])
        );
    end

    // ---------------- Gain stage after the pitch rotation ----------------
    logic                 r_u4_valid;
    logic signed [ZW-1:0] r_u4_roll;
    logic signed [ZW-1:0] r_u4_pitch;
    logic signed [XW-1:0] r_u4_by;
    logic signed [XW-1:0] r_u4_bx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u4_valid <= 1'b0;
        end else if (en) begin
            r_u4_valid <= w4_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u4_roll  <= $signed(w4_side[N][S4W-1:ZW+XW]);
            r_u4_pitch <= $signed(w4_side[N][ZW+XW-1:XW]);
            r_u4_by    <= $signed(w4_side[N][XW-1:0]);
            r_u4_bx    <= tcc_pkg::unscale(w4_cv[N].x);
        end
    end

    // ---------------- Setup stage for the heading row ----------------
    logic                 r_p5_valid;
    tcc_pkg::t_cv         r_p5_cv;
    logic [S5W-1:0]       r_p5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_valid <= 1'b0;
        end else if (en) begin
            r_p5_valid <= r_u4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p5_cv   <= tcc_pkg::vec_prep(r_u4_bx, r_u4_by);
            r_p5_side <= {r_u4_roll, r_u4_pitch, (r_u4_bx == 0 && r_u4_by == 0)};
        end
    end

    // ---------------- Heading vectoring row ----------------
    logic                 w5_valid [0:N];
    tcc_pkg::t_cv         w5_cv    [0:N];
    logic [S5W-1:0]       w5_side  [0:N];

    assign w5_valid[0] = r_p5_valid;
    assign w5_cv[0]    = r_p5_cv;
    assign w5_side[0]  = r_p5_side;

    for (genvar k = 0; k < N; k++) begin : g_row5
        tcc_vec_cell #(.STEP(k), .SIDE_W(S5W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w5_valid[k]),
            .i_cv    (w5_cv[k]),
            .i_side  (w5_side[k]),
            .o_valid (w5_valid[k+1]),
            .o_cv    (w5_cv[k+1]),
            .o_side  (w5_side[k+1])
        );
    end

    // ---------------- Output register ----------------
    // Rounds an internal angle (pi = 2^31) to the output width; +pi wraps to -pi.
    function automatic logic signed [ANGLE_BITS-1:0] angle_out(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] r;
        r = z + (ZW'(1) << (31 - ANGLE_BITS));
        return $signed(r[31:32-ANGLE_BITS]);
    endfunction

    logic signed [ZW-1:0] out_roll;
    logic signed [ZW-1:0] out_pitch;
    logic signed [ZW-1:0] out_head;

    assign out_roll  = $signed(w5_side[N][S5W-1:ZW+1]);
    assign out_pitch = $signed(w5_side[N][ZW:1]);
    assign out_head  = w5_side[N][0] ? '0 : w5_cv[N].z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= w5_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_roll_angle    <= angle_out(out_roll);
            o_pitch_angle   <= angle_out(out_pitch);
            o_heading_angle <= angle_out(out_head);
        end
    end

endmodule
`default_nettype wire
